/* sv/ssrrip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RRIP replacement package
// Shared widths, codes, reset values and the PC signature hash.
// ----------------------------------------------------------------------------
package ssrrip_pkg;

    // Transfer field widths.
    localparam int OP_W       = 1;
    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int ADDR_W     = 64;
    localparam int PC_W       = 64;
    localparam int VICTIM_W   = 4;

    // Metadata widths.
    localparam int RRPV_W     = 2;
    localparam int SIG_W      = 6;
    localparam int SIG_COUNT  = 64;
    localparam int CTR_W      = 2;
    localparam int SCORE_W    = 8;

    // Configuration port.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int STREAM_THR_W = 8;
    localparam int REUSE_THR_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_THR  = 1'b1;

    localparam logic [STREAM_THR_W-1:0] STREAM_THR_RESET = 8'd32;
    localparam logic [REUSE_THR_W-1:0]  REUSE_THR_RESET  = 2'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_VICTIM = 1'b0;
    localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

    // Re-reference values.
    localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

    localparam logic [CTR_W-1:0]   CTR_MAX   = 2'd3;
    localparam logic [CTR_W-1:0]   CTR_RESET = 2'd1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

    // Default geometry.
    localparam int NUM_SETS_DEF = 2048;
    localparam int NUM_WAYS_DEF = 16;

    // Fold three 6-bit slices of the PC into the signature.
    function automatic logic [SIG_W-1:0] sig_hash(input logic [PC_W-1:0] pc);
        sig_hash = pc[SIG_W-1:0] ^ pc[2*SIG_W-1:SIG_W] ^ pc[3*SIG_W-1:2*SIG_W];
    endfunction

endpackage
`default_nettype wire

/* sv/ssrrip_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RRIP request channel
// Valid/ready channel carrying victim requests and state updates.
// ----------------------------------------------------------------------------
interface ssrrip_in_if
    import ssrrip_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [ADDR_W-1:0]   phys_addr;
    logic [PC_W-1:0]     pc_value;
    logic                was_hit;

    modport source (
        output valid, op, set_index, way_index, phys_addr, pc_value, was_hit,
        input  ready
    );

    modport sink (
        input  valid, op, set_index, way_index, phys_addr, pc_value, was_hit,
        output ready
    );
endinterface
`default_nettype wire

/* sv/ssrrip_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RRIP victim channel
// Valid/ready channel carrying the chosen victim way.
// ----------------------------------------------------------------------------
interface ssrrip_out_if
    import ssrrip_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [VICTIM_W-1:0] victim_way;

    modport source (
        output valid, victim_way,
        input  ready
    );

    modport sink (
        input  valid, victim_way,
        output ready
    );
endinterface
`default_nettype wire

/* sv/ship_stream_rrip_replacement_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHiP / SRRIP replacement core with per-set stream detection
// Keeps per-set re-reference values, fill signatures and a stride detector in
// one row memory, plus a 64-entry signature reuse counter memory.
// ----------------------------------------------------------------------------
// Flow: a victim request passes S_RD and S_EVAL and then leaves its way in the
//   result register; an update passes S_RD, S_EVAL and S_WB. No new request
//   is taken until the last one is through, as set by the read-modify-write of
//   the set row memory and, for an update, by the dependent second read of the
//   reuse counter memory. A victim request also waits while the result register
//   still holds an earlier way.
// Reset: synchronous; a clearing pass over max(NUM_SETS, 64) addresses (2048 by
//   default) initializes both memories; no request is taken until it ends.
// ----------------------------------------------------------------------------
module ship_stream_rrip_replacement_core
    import ssrrip_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF,
    parameter int NUM_WAYS = NUM_WAYS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    ssrrip_in_if.sink            i_in,
    ssrrip_out_if.source         o_out,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int CLR_N     = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
    localparam int CLR_W     = $clog2(CLR_N);
    // The set index reduction is split across the transfer cycle and the
    // read cycle: the upper steps run on transfer, the lower ones on read.
    localparam int MOD_SPLIT = 6;

    // One memory row holds everything the replacement policy keeps per set.
    typedef struct packed {
        logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv;
        logic [NUM_WAYS-1:0][SIG_W-1:0]  sig;
        logic [ADDR_W-1:0]               prev_addr;
        logic [ADDR_W-1:0]               prev_delta;
        logic [SCORE_W-1:0]              score;
    } t_row;

    // S_CLR sweeps both memories after reset. S_RD reads the set row and the
    // counter of the new signature. S_EVAL finishes a victim request, or for
    // an update runs the stride detector and reads the evicted block's
    // counter. S_WB writes the updated row and counter back.
    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EVAL = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    // Control registers.
    t_state                   r_state, n_state;
    logic [CLR_W-1:0]         r_clr_idx;
    logic                     r_out_valid;
    logic [STREAM_THR_W-1:0]  r_stream_thr;
    logic [REUSE_THR_W-1:0]   r_reuse_thr;

    // Payload registers of the request in flight.
    logic [OP_W-1:0]          r_op;
    logic [SET_IN_W-1:0]      r_set_part, n_set_part;
    logic [SET_W-1:0]         r_set_idx;
    logic [WAY_W-1:0]         r_way, n_way;
    logic [ADDR_W-1:0]        r_addr;
    logic [SIG_W-1:0]         r_sig;
    logic                     r_hit;
    logic [SIG_W-1:0]         r_old_sig;
    logic [ADDR_W-1:0]        r_delta;
    logic [SCORE_W-1:0]       r_score_new, n_score_new;
    logic [VICTIM_W-1:0]      r_victim;

    // Memories and their registered read data.
    t_row                     r_set_mem [NUM_SETS];
    t_row                     r_row;
    logic [CTR_W-1:0]         r_ctr_mem [SIG_COUNT];
    logic [CTR_W-1:0]         r_ctr_a;
    logic [CTR_W-1:0]         r_ctr_b;

    // Combinational signals.
    logic                     in_xfer;
    logic                     out_free;
    logic                     clr_done;
    logic                     clr_set_en;
    logic                     clr_ctr_en;
    logic [SET_IN_W-1:0]      set_rem;
    logic [SET_W-1:0]         set_rd_idx;
    logic                     victim_go;
    logic [RRPV_W-1:0]        top_rrpv;
    logic [RRPV_W-1:0]        age;
    logic [NUM_WAYS-1:0][RRPV_W-1:0] aged_rrpv;
    logic [WAY_W-1:0]         victim_sel;
    logic [SIG_W-1:0]         old_sig_rd;
    logic [ADDR_W-1:0]        delta;
    logic                     stride_match;
    logic                     streaming;
    logic [CTR_W-1:0]         ctr_inc;
    logic [CTR_W-1:0]         ctr_dec;
    logic [CTR_W-1:0]         ctr_sig_eff;
    logic [RRPV_W-1:0]        ins_rrpv;
    t_row                     row_clr;
    t_row                     row_aged;
    t_row                     row_upd;
    logic                     set_we;
    logic [SET_W-1:0]         set_waddr;
    t_row                     set_wdata;
    logic                     ctr_we;
    logic [SIG_W-1:0]         ctr_waddr;
    logic [CTR_W-1:0]         ctr_wdata;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign i_in.ready       = (r_state == S_IDLE);
    assign in_xfer          = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.victim_way = r_victim;
    // The result register can take a new victim when it is empty or is
    // being drained by a transfer in this cycle.
    assign out_free         = !r_out_valid || o_out.ready;
    assign victim_go        = (r_state == S_EVAL) && (r_op == OP_VICTIM) && out_free;

    // ------------------------------------------------------------------
    // Index reduction: set_index modulo NUM_SETS and way_index modulo
    // NUM_WAYS, as restoring compare-and-subtract steps.
    // ------------------------------------------------------------------
    always_comb begin
        n_set_part = i_in.set_index;
        for (int k = SET_IN_W - 1; k >= MOD_SPLIT; k--) begin
            if (32'(n_set_part) >= (32'(NUM_SETS) << k)) begin
                n_set_part = n_set_part - SET_IN_W'(32'(NUM_SETS) << k);
            end
        end
    end

    always_comb begin
        set_rem = r_set_part;
        for (int k = MOD_SPLIT - 1; k >= 0; k--) begin
            if (32'(set_rem) >= (32'(NUM_SETS) << k)) begin
                set_rem = set_rem - SET_IN_W'(32'(NUM_SETS) << k);
            end
        end
        set_rd_idx = SET_W'(set_rem);
    end

    always_comb begin
        logic [WAY_IN_W-1:0] way_rem;
        way_rem = i_in.way_index;
        for (int k = WAY_IN_W - 1; k >= 0; k--) begin
            if (32'(way_rem) >= (32'(NUM_WAYS) << k)) begin
                way_rem = way_rem - WAY_IN_W'(32'(NUM_WAYS) << k);
            end
        end
        n_way = WAY_W'(way_rem);
    end

    // ------------------------------------------------------------------
    // Victim selection: the largest value is found bit by bit, the row is
    // aged so that it reaches the maximum, and the lowest way holding the
    // maximum is chosen. Aging by zero leaves a row unchanged, so the aged
    // row is always written back.
    // ------------------------------------------------------------------
    always_comb begin
        logic msb_any;
        logic lsb_any;
        msb_any = 1'b0;
        lsb_any = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            msb_any = msb_any | r_row.rrpv[w][1];
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            lsb_any = lsb_any | (r_row.rrpv[w][0] & (r_row.rrpv[w][1] == msb_any));
        end
        top_rrpv = {msb_any, lsb_any};
        age      = RRPV_MAX - top_rrpv;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_rrpv[w] = r_row.rrpv[w] + age;
        end
        victim_sel = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (aged_rrpv[w] == RRPV_MAX) begin
                victim_sel = WAY_W'(w);
            end
        end
        row_aged      = r_row;
        row_aged.rrpv = aged_rrpv;
    end

    // ------------------------------------------------------------------
    // Stride detector, evaluated while the row is held in S_EVAL.
    // ------------------------------------------------------------------
    always_comb begin
        delta        = r_addr - r_row.prev_addr;
        stride_match = (delta == r_row.prev_delta) && (delta != '0);
        if (stride_match) begin
            n_score_new = (r_row.score == SCORE_MAX) ? r_row.score : r_row.score + 1'b1;
        end else begin
            n_score_new = (r_row.score == '0) ? r_row.score : r_row.score - 1'b1;
        end
        old_sig_rd = r_row.sig[r_way];
    end

    // ------------------------------------------------------------------
    // Update write-back. On a miss the evicted signature's counter drops
    // first; when it is also the new signature, the insertion decision sees
    // the lowered value.
    // ------------------------------------------------------------------
    always_comb begin
        streaming   = (r_score_new >= r_stream_thr);
        ctr_inc     = (r_ctr_a == CTR_MAX) ? r_ctr_a : r_ctr_a + 1'b1;
        ctr_dec     = (r_ctr_b == '0) ? r_ctr_b : r_ctr_b - 1'b1;
        ctr_sig_eff = (r_old_sig == r_sig) ? ctr_dec : r_ctr_a;
        if (streaming) begin
            ins_rrpv = RRPV_MAX;
        end else if (ctr_sig_eff >= r_reuse_thr) begin
            ins_rrpv = RRPV_NEAR;
        end else begin
            ins_rrpv = RRPV_LONG;
        end

        row_upd            = r_row;
        row_upd.prev_addr  = r_addr;
        row_upd.prev_delta = r_delta;
        row_upd.score      = r_score_new;
        if (r_hit) begin
            row_upd.rrpv[r_way] = RRPV_NEAR;
        end else begin
            row_upd.rrpv[r_way] = ins_rrpv;
            row_upd.sig[r_way]  = r_sig;
        end
    end

    // Reset row: every way at the maximum re-reference value, all else zero.
    always_comb begin
        row_clr = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_clr.rrpv[w] = RRPV_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Memory write port selection.
    // ------------------------------------------------------------------
    assign clr_done   = (r_clr_idx == CLR_W'(CLR_N - 1));
    assign clr_set_en = (r_state == S_CLR) && (32'(r_clr_idx) < NUM_SETS);
    assign clr_ctr_en = (r_state == S_CLR) && (32'(r_clr_idx) < SIG_COUNT);

    always_comb begin
        set_we    = 1'b0;
        set_waddr = r_set_idx;
        set_wdata = row_upd;
        if (clr_set_en) begin
            set_we    = 1'b1;
            set_waddr = r_clr_idx[SET_W-1:0];
            set_wdata = row_clr;
        end else if (victim_go) begin
            set_we    = 1'b1;
            set_wdata = row_aged;
        end else if (r_state == S_WB) begin
            set_we    = 1'b1;
        end
    end

    always_comb begin
        ctr_we    = 1'b0;
        ctr_waddr = r_old_sig;
        ctr_wdata = ctr_dec;
        if (clr_ctr_en) begin
            ctr_we    = 1'b1;
            ctr_waddr = r_clr_idx[SIG_W-1:0];
            ctr_wdata = CTR_RESET;
        end else if (r_state == S_WB) begin
            ctr_we = 1'b1;
            if (r_hit) begin
                ctr_waddr = r_sig;
                ctr_wdata = ctr_inc;
            end
        end
    end

    // Set row memory: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (set_we) begin
            r_set_mem[set_waddr] <= set_wdata;
        end
        if (r_state == S_RD) begin
            r_row <= r_set_mem[set_rd_idx];
        end
    end

    // Reuse counter memory: one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (ctr_we) begin
            r_ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (r_state == S_RD) begin
            r_ctr_a <= r_ctr_mem[r_sig];
        end
        if ((r_state == S_EVAL) && (r_op == OP_UPDATE)) begin
            r_ctr_b <= r_ctr_mem[old_sig_rd];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_op == OP_UPDATE) begin
                    n_state = S_WB;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WB: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_idx    <= '0;
            r_out_valid  <= 1'b0;
            r_stream_thr <= STREAM_THR_RESET;
            r_reuse_thr  <= REUSE_THR_RESET;
        end else begin
            r_state <= n_state;
            if ((r_state == S_CLR) && !clr_done) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (victim_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STREAM_THR: r_stream_thr <= STREAM_THR_W'(i_cfg_data);
                    CFG_REUSE_THR:  r_reuse_thr  <= REUSE_THR_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op       <= i_in.op;
            r_set_part <= n_set_part;
            r_way      <= n_way;
            r_addr     <= i_in.phys_addr;
            r_sig      <= sig_hash(i_in.pc_value);
            r_hit      <= i_in.was_hit;
        end
        if (r_state == S_RD) begin
            r_set_idx <= set_rd_idx;
        end
        if ((r_state == S_EVAL) && (r_op == OP_UPDATE)) begin
            r_delta     <= delta;
            r_score_new <= n_score_new;
            r_old_sig   <= old_sig_rd;
        end
        if (victim_go) begin
            r_victim <= VICTIM_W'(victim_sel);
        end
    end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHiP / SRRIP replacement core testbench
// Drives victim requests and replacement state updates through the request
// channel and checks every victim way against a cycle-free predictor of the
// re-reference values, fill signatures, reuse counters and stride detectors.
// ----------------------------------------------------------------------------
module testbench;
    import ssrrip_pkg::*;

    localparam int SETS = NUM_SETS_DEF;
    localparam int WAYS = NUM_WAYS_DEF;
    localparam int POOL = 8;

    // One request transfer as the sender builds it.
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [ADDR_W-1:0]   phys_addr;
        logic [PC_W-1:0]     pc_value;
        logic                was_hit;
    } t_rrip_req;

    // The scoreboard keeps its own copy of every piece of replacement state.
    // A victim request is resolved at the moment its transfer is accepted and
    // the chosen way is queued until the victim channel delivers it.
    class rrip_scoreboard;
        logic [RRPV_W-1:0]       rrpv_mem     [SETS*WAYS];
        logic [SIG_W-1:0]        fill_sig_mem [SETS*WAYS];
        logic [CTR_W-1:0]        reuse_ctr    [SIG_COUNT];
        logic [ADDR_W-1:0]       seen_addr    [SETS];
        logic [ADDR_W-1:0]       seen_stride  [SETS];
        logic [SCORE_W-1:0]      run_score    [SETS];
        logic [STREAM_THR_W-1:0] stream_thr;
        logic [REUSE_THR_W-1:0]  reuse_thr;
        logic [VICTIM_W-1:0]     victim_ways_due[$];
        int mismatches    = 0;
        int victim_reqs   = 0;
        int aged_sets     = 0;
        int updates       = 0;
        int hits          = 0;
        int distant_fills = 0;
        int near_fills    = 0;
        int long_fills    = 0;
        int saturations   = 0;

        function new();
            foreach (rrpv_mem[i]) begin
                rrpv_mem[i]     = RRPV_MAX;
                fill_sig_mem[i] = '0;
            end
            foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_RESET;
            foreach (seen_addr[i]) begin
                seen_addr[i]   = '0;
                seen_stride[i] = '0;
                run_score[i]   = '0;
            end
            stream_thr = STREAM_THR_RESET;
            reuse_thr  = REUSE_THR_RESET;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_STREAM_THR) begin
                stream_thr = data[STREAM_THR_W-1:0];
            end else begin
                reuse_thr = data[REUSE_THR_W-1:0];
            end
        endfunction

        function int pending();
            return victim_ways_due.size();
        endfunction

        function void note_request(t_rrip_req r);
            int unsigned      set_i;
            int unsigned      row;
            int unsigned      blk;
            int unsigned      pick;
            bit               found;
            logic [RRPV_W-1:0] top;
            logic [RRPV_W-1:0] age;
            logic [ADDR_W-1:0] delta;
            logic [SIG_W-1:0]  sig;
            logic [SIG_W-1:0]  old_sig;
            bit                streaming;

            set_i = int'(r.set_index) % SETS;
            row   = set_i * WAYS;

            if (r.op == OP_VICTIM) begin
                victim_reqs++;
                top = '0;
                for (int w = 0; w < WAYS; w++)
                    if (rrpv_mem[row+w] > top) top = rrpv_mem[row+w];
                // No distant block: age the whole set until the oldest one is distant.
                if (top < RRPV_MAX) begin
                    age = RRPV_MAX - top;
                    for (int w = 0; w < WAYS; w++) rrpv_mem[row+w] = rrpv_mem[row+w] + age;
                    aged_sets++;
                end
                pick  = 0;
                found = 1'b0;
                for (int w = 0; w < WAYS; w++) begin
                    if (!found && rrpv_mem[row+w] == RRPV_MAX) begin
                        pick  = w;
                        found = 1'b1;
                    end
                end
                victim_ways_due.push_back(VICTIM_W'(pick));
                return;
            end

            updates++;
            // Stride detector: a repeated nonzero delta raises the score.
            delta = r.phys_addr - seen_addr[set_i];
            if (delta == seen_stride[set_i] && delta != '0) begin
                if (run_score[set_i] != SCORE_MAX) begin
                    run_score[set_i]++;
                    if (run_score[set_i] == SCORE_MAX) saturations++;
                end
            end else if (run_score[set_i] != '0) begin
                run_score[set_i]--;
            end
            seen_stride[set_i] = delta;
            seen_addr[set_i]   = r.phys_addr;
            streaming = (run_score[set_i] >= stream_thr);

            sig = SIG_W'(r.pc_value ^ (r.pc_value >> 6) ^ (r.pc_value >> 12));
            blk = row + (int'(r.way_index) % WAYS);

            if (r.was_hit) begin
                hits++;
                rrpv_mem[blk] = RRPV_NEAR;
                if (reuse_ctr[sig] != CTR_MAX) reuse_ctr[sig]++;
                return;
            end

            // The evicted block's signature is penalized before the new one is read.
            old_sig = fill_sig_mem[blk];
            if (reuse_ctr[old_sig] != '0) reuse_ctr[old_sig]--;
            if (streaming) begin
                rrpv_mem[blk] = RRPV_MAX;
                distant_fills++;
            end else if (reuse_ctr[sig] >= reuse_thr) begin
                rrpv_mem[blk] = RRPV_NEAR;
                near_fills++;
            end else begin
                rrpv_mem[blk] = RRPV_LONG;
                long_fills++;
            end
            fill_sig_mem[blk] = sig;
        endfunction

        function void check_victim(logic [VICTIM_W-1:0] actual);
            logic [VICTIM_W-1:0] due;
            if (victim_ways_due.size() == 0) begin
                $display("%0t: victim_way expected none, actual %0d", $time, actual);
                mismatches++;
                return;
            end
            due = victim_ways_due.pop_front();
            if (due !== actual) begin
                $display("%0t: victim_way expected %0d, actual %0d", $time, due, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssrrip_in_if  req_if ();
    ssrrip_out_if vict_if ();

    ship_stream_rrip_replacement_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (vict_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rrip_scoreboard sb = new();

    // Idle rates in percent, set per phase by the stimulus process.
    int send_idle_pct;
    int recv_idle_pct;
    // A long receiver hold-off is requested here and counted down below.
    int hold_req  = 0;
    int hold_left = 0;

    // Per-phase working set: slot 0 is the hot set, and each slot carries its
    // own running address and stride so that updates form stride runs.
    logic [SET_IN_W-1:0] set_pool   [POOL];
    logic [ADDR_W-1:0]   run_addr   [POOL];
    logic [ADDR_W-1:0]   run_stride [POOL];
    logic [PC_W-1:0]     pc_pool    [POOL];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run including the clearing pass.
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Victim channel receiver: checks each transfer and drives ready, with a
    // random stall rate and an occasional long hold-off so the core backs up.
    always @(posedge i_clk) begin
        if (vict_if.valid && vict_if.ready) sb.check_victim(vict_if.victim_way);
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            vict_if.ready <= 1'b0;
        end else begin
            vict_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_rrip_req make_req(logic [OP_W-1:0] op, int set_i, int way,
                                           logic [ADDR_W-1:0] addr, logic [PC_W-1:0] pc,
                                           logic hit);
        t_rrip_req r;
        r.op        = op;
        r.set_index = SET_IN_W'(set_i);
        r.way_index = WAY_IN_W'(way);
        r.phys_addr = addr;
        r.pc_value  = pc;
        r.was_hit   = hit;
        return r;
    endfunction

    // Small forward or backward strides mostly, sometimes one that wraps.
    function automatic logic [ADDR_W-1:0] pick_stride();
        case ($urandom_range(0, 2))
            0:       return ADDR_W'($urandom_range(1, 8)) << 6;
            1:       return -(ADDR_W'($urandom_range(1, 8)) << 6);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random request: a little pure noise, the rest aimed at the working set
    // with stride runs that are occasionally broken by a jump, a repeated
    // address or a new stride.
    function automatic t_rrip_req next_request(int hot_pct, int break_pct);
        t_rrip_req r;
        int        s;
        r.op        = ($urandom_range(0, 99) < 35) ? OP_VICTIM : OP_UPDATE;
        r.way_index = WAY_IN_W'($urandom);
        r.was_hit   = $urandom_range(0, 1);
        r.phys_addr = {$urandom, $urandom};
        r.pc_value  = pc_pool[$urandom_range(0, POOL-1)];
        if ($urandom_range(0, 99) < 8) begin
            r.op        = OP_W'($urandom);
            r.set_index = SET_IN_W'($urandom);
            r.pc_value  = {$urandom, $urandom};
            return r;
        end
        s = ($urandom_range(0, 99) < hot_pct) ? 0 : $urandom_range(1, POOL-1);
        r.set_index = set_pool[s];
        if (r.op == OP_UPDATE) begin
            if ($urandom_range(0, 99) < break_pct) begin
                case ($urandom_range(0, 2))
                    0: r.phys_addr = run_addr[s];
                    1: r.phys_addr = {$urandom, $urandom};
                    default: begin
                        run_stride[s] = pick_stride();
                        r.phys_addr   = run_addr[s] + run_stride[s];
                    end
                endcase
            end else begin
                r.phys_addr = run_addr[s] + run_stride[s];
            end
            run_addr[s] = r.phys_addr;
        end
        return r;
    endfunction

    // Offer one request and return at the edge where it is transferred. The
    // valid is only lowered during an idle gap, never between two requests
    // offered back to back.
    task automatic send_request(input t_rrip_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= r.op;
        req_if.set_index <= r.set_index;
        req_if.way_index <= r.way_index;
        req_if.phys_addr <= r.phys_addr;
        req_if.pc_value  <= r.pc_value;
        req_if.was_hit   <= r.was_hit;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    // Stop offering, wait for every victim way still due, then give a trailing
    // update time to finish its read-modify-write.
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // New phase: quiesce, write both thresholds, pick a fresh working set.
    task automatic begin_phase(input logic [STREAM_THR_W-1:0] stream_thr,
                               input logic [REUSE_THR_W-1:0] reuse_thr,
                               input int send_idle, input int recv_idle);
        logic [CFG_DATA_W-1:0] reuse_word;
        settle();
        // Bits above the reuse threshold field carry random junk.
        reuse_word = {CFG_DATA_W'($urandom) >> REUSE_THR_W << REUSE_THR_W} | reuse_thr;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STREAM_THR;
        cfg_data <= stream_thr;
        @(posedge i_clk);
        sb.write_register(CFG_STREAM_THR, stream_thr);
        cfg_idx  <= CFG_REUSE_THR;
        cfg_data <= reuse_word;
        @(posedge i_clk);
        sb.write_register(CFG_REUSE_THR, reuse_word);
        cfg_we <= 1'b0;
        for (int i = 0; i < POOL; i++) begin
            set_pool[i]   = SET_IN_W'($urandom);
            run_addr[i]   = {$urandom, $urandom};
            run_stride[i] = pick_stride();
            pc_pool[i]    = {$urandom, $urandom};
        end
        set_pool[1]   = '0;
        set_pool[2]   = SET_IN_W'(SETS - 1);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
    endtask

    task automatic run_random(input int count, input int hot_pct, input int break_pct,
                              input int hold_at, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) hold_req = 240;
            if (k == pause_at) settle();
            send_request(next_request(hot_pct, break_pct));
        end
    endtask

    initial begin
        req_if.valid     = 1'b0;
        req_if.op        = OP_VICTIM;
        req_if.set_index = '0;
        req_if.way_index = '0;
        req_if.phys_addr = '0;
        req_if.pc_value  = '0;
        req_if.was_hit   = 1'b0;
        vict_if.ready    = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_STREAM_THR;
        cfg_data         = '0;
        i_rst_n          = 1'b0;
        send_idle_pct    = 23;
        recv_idle_pct    = 46;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset thresholds. The clearing pass after
        // reset simply shows up as a long stretch without ready.
        // A fresh set has every way distant, so the first victim is way 0.
        send_request(make_req(OP_VICTIM, 0, 0, '0, '0, 1'b0));
        // Miss with a zero address: the first delta is zero and cannot count
        // as a stride; signature 0 loses its counter and the fill goes long.
        send_request(make_req(OP_UPDATE, 0, 0, '0, '0, 1'b0));
        send_request(make_req(OP_VICTIM, 0, 9, {ADDR_W{1'b1}}, {PC_W{1'b1}}, 1'b1));
        // Hit on the top way with every address and PC bit set.
        send_request(make_req(OP_UPDATE, 0, WAYS-1, {ADDR_W{1'b1}}, {PC_W{1'b1}}, 1'b1));
        // Last set: promote fifteen ways by hits along a stride, then fill the
        // last way on a miss with a fresh signature, so that the next victim
        // has to age the whole set by one step.
        for (int w = 0; w < WAYS-1; w++)
            send_request(make_req(OP_UPDATE, SETS-1, w, ADDR_W'(w) << 6, '0, 1'b1));
        send_request(make_req(OP_UPDATE, SETS-1, WAYS-1, ADDR_W'(WAYS-1) << 6,
                              PC_W'('h40), 1'b0));
        send_request(make_req(OP_VICTIM, SETS-1, 0, '0, '0, 1'b0));
        send_request(make_req(OP_VICTIM, SETS-1, 0, '0, '0, 1'b0));

        // Random phases. The first two use the first idle pattern, the next two
        // the swapped one, the last runs without idling. Thresholds cover the
        // reset values and both extremes of each register.
        begin_phase(8'd32, 2'd2, 23, 46);
        run_random(350, 30, 10, 60, -1);
        begin_phase(8'd0, 2'd0, 23, 46);
        run_random(250, 20, 15, -1, -1);
        // One hot set runs an almost unbroken stride so its score saturates.
        begin_phase(8'd255, 2'd3, 46, 23);
        run_random(600, 90, 1, 200, -1);
        begin_phase(8'd4, 2'd1, 46, 23);
        run_random(300, 30, 10, -1, 150);
        begin_phase(8'd1, 2'd3, 0, 0);
        run_random(350, 40, 8, 100, 200);

        settle();
        $display("Run covered %0d victim requests (%0d needing aging) and %0d updates (%0d hits).",
                 sb.victim_reqs, sb.aged_sets, sb.updates, sb.hits);
        $display("Miss fills: %0d streaming, %0d near, %0d long; %0d stream scores saturated.",
                 sb.distant_fills, sb.near_fills, sb.long_fills, sb.saturations);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
